// File: sv/rbe_pkg.sv
// Shared types, codes and helpers of the rigid body integrator.
package rbe_pkg;

   // Action codes carried on the request channel
   localparam logic [1:0] ACT_FORCE  = 2'd0;
   localparam logic [1:0] ACT_SETVEL = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   // Register indexes (paddr[4:2])
   localparam int unsigned CSR_AW = 5;
   localparam logic [2:0] REG_INV_MASS  = 3'd0;
   localparam logic [2:0] REG_FRICTION  = 3'd1;
   localparam logic [2:0] REG_GRAV_EN   = 3'd2;
   localparam logic [2:0] REG_GRAV_ACC  = 3'd3;
   localparam logic [2:0] REG_SPEED_LIM = 3'd4;

   // Wide sum width: 32 bit state plus a signed 49 bit product
   localparam int unsigned SUM_W = 50;
   localparam logic signed [SUM_W-1:0] SUM_MAX = 50'sh0_7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = -50'sh0_8000_0000;
   localparam logic signed [SUM_W-1:0] Q_ONE   = 50'sd65536;

   typedef struct packed {
      logic [31:0] inv_mass;
      logic [31:0] friction_coeff;
      logic        gravity_enable;
      logic [30:0] gravity_accel;
      logic [30:0] speed_limit;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic        ack;
      logic [1:0]  action;
      logic [15:0] dt;
   } lane_ctl_type;

   typedef struct packed {
      logic done;
   } lane_stat_type;

   typedef enum logic [3:0] {
      L_IDLE,
      L_FORCE_MUL,
      L_FORCE_ADD,
      L_GRAV_MUL,
      L_GRAV_ADD,
      L_FRIC_MUL,
      L_FRIC_SAT,
      L_FMASS_MUL,
      L_FMASS_ADD,
      L_VEL_MUL,
      L_VEL_ADD,
      L_DISP_MUL,
      L_DISP_SET,
      L_DONE
   } lane_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v > SUM_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SUM_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: sv/rbe_ifs.sv
// Request and response channel interfaces of the rigid body integrator.
interface rbe_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] value_x;
   logic signed [31:0] value_y;
   logic [15:0]        delta_time;

   modport source (output valid, action, value_x, value_y, delta_time, input ready);
   modport sink   (input valid, action, value_x, value_y, delta_time, output ready);
endinterface

interface rbe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] velocity_x;
   logic signed [31:0] velocity_y;
   logic signed [31:0] displacement_x;
   logic signed [31:0] displacement_y;

   modport source (output valid, velocity_x, velocity_y, displacement_x, displacement_y,
                   input ready);
   modport sink   (input valid, velocity_x, velocity_y, displacement_x, displacement_y,
                   output ready);
endinterface

// File: sv/rbe_csr.sv
// APB-style configuration register file of the rigid body integrator.
module rbe_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rbe_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output rbe_pkg::cfg_type           cfg
);

   rbe_pkg::cfg_type cfg_ff;
   rbe_pkg::cfg_type cfg_in;
   logic [2:0]       index;
   logic             wr;

   assign index  = paddr[rbe_pkg::CSR_AW-1:2];
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (index)
            rbe_pkg::REG_INV_MASS:  cfg_in.inv_mass       = pwdata;
            rbe_pkg::REG_FRICTION:  cfg_in.friction_coeff = pwdata;
            rbe_pkg::REG_GRAV_EN:   cfg_in.gravity_enable = pwdata[0];
            rbe_pkg::REG_GRAV_ACC:  cfg_in.gravity_accel  = pwdata[30:0];
            rbe_pkg::REG_SPEED_LIM: cfg_in.speed_limit    = pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         rbe_pkg::REG_INV_MASS:  prdata = cfg_ff.inv_mass;
         rbe_pkg::REG_FRICTION:  prdata = cfg_ff.friction_coeff;
         rbe_pkg::REG_GRAV_EN:   prdata = {31'd0, cfg_ff.gravity_enable};
         rbe_pkg::REG_GRAV_ACC:  prdata = {1'b0, cfg_ff.gravity_accel};
         rbe_pkg::REG_SPEED_LIM: prdata = {1'b0, cfg_ff.speed_limit};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_mass       <= 32'd65536;
         cfg_ff.friction_coeff <= 32'd0;
         cfg_ff.gravity_enable <= 1'b0;
         cfg_ff.gravity_accel  <= 31'd642252;
         cfg_ff.speed_limit    <= 31'd655360;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/rbe_lane.sv
// One axis of the integrator: velocity, acceleration, displacement and one reused Q16.16 multiplier.
module rbe_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  rbe_pkg::lane_ctl_type   ctl,
   input  logic signed [31:0]      value,
   input  rbe_pkg::cfg_type        cfg,
   input  logic                    grav_use,
   input  logic [30:0]             limit,
   output rbe_pkg::lane_stat_type  stat,
   output logic signed [31:0]      vel,
   output logic signed [31:0]      disp
);

   rbe_pkg::lane_state_type state_ff, state_in;
   logic signed [31:0] vel_ff, vel_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] disp_ff, disp_in;
   logic signed [31:0] opnd_ff, opnd_in;
   logic [15:0]        dt_ff, dt_in;
   logic [47:0]        q_ff, q_in;
   logic               neg_ff, neg_in;

   logic [31:0]        mul_a;
   logic [31:0]        mul_b;
   logic [31:0]        mag;
   logic [63:0]        prod;

   logic signed [rbe_pkg::SUM_W-1:0] qext;
   logic signed [rbe_pkg::SUM_W-1:0] sp;
   logic signed [rbe_pkg::SUM_W-1:0] acc_sum;
   logic signed [rbe_pkg::SUM_W-1:0] vel_sum;
   logic signed [rbe_pkg::SUM_W-1:0] lim;
   logic signed [rbe_pkg::SUM_W-1:0] clip;
   logic signed [31:0]               settled;

   // Sign-magnitude multiply, truncation toward zero after the >> 16
   assign mag    = mul_a[31] ? (32'd0 - mul_a) : mul_a;
   assign prod   = 64'(mag) * 64'(mul_b);
   assign q_in   = prod[63:16];
   assign neg_in = mul_a[31];

   assign qext    = $signed({2'b00, q_ff});
   assign sp      = neg_ff ? -qext : qext;
   assign acc_sum = $signed({{18{acc_ff[31]}}, acc_ff}) + sp;
   assign vel_sum = $signed({{18{vel_ff[31]}}, vel_ff}) + sp;
   assign lim     = $signed({19'd0, limit});

   always_comb begin
      if (vel_sum > lim) begin
         clip = lim;
      end else if (vel_sum < -lim) begin
         clip = -lim;
      end else begin
         clip = vel_sum;
      end
      if (clip >= -rbe_pkg::Q_ONE && clip <= rbe_pkg::Q_ONE) begin
         settled = '0;
      end else begin
         settled = clip[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      vel_in   = vel_ff;
      acc_in   = acc_ff;
      disp_in  = disp_ff;
      opnd_in  = opnd_ff;
      dt_in    = dt_ff;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         rbe_pkg::L_IDLE: begin
            if (ctl.start) begin
               opnd_in = value;
               dt_in   = ctl.dt;
               disp_in = '0;
               unique case (ctl.action)
                  rbe_pkg::ACT_FORCE:  state_in = rbe_pkg::L_FORCE_MUL;
                  rbe_pkg::ACT_SETVEL: begin
                     vel_in   = value;
                     state_in = rbe_pkg::L_DONE;
                  end
                  rbe_pkg::ACT_TICK: begin
                     state_in = cfg.gravity_enable ? rbe_pkg::L_GRAV_MUL
                                                   : rbe_pkg::L_FRIC_MUL;
                  end
                  default: state_in = rbe_pkg::L_DONE;
               endcase
            end
         end
         rbe_pkg::L_FORCE_MUL: begin
            mul_a    = opnd_ff;
            mul_b    = cfg.inv_mass;
            state_in = rbe_pkg::L_FORCE_ADD;
         end
         rbe_pkg::L_FORCE_ADD: begin
            acc_in   = rbe_pkg::sat32(acc_sum);
            state_in = rbe_pkg::L_DONE;
         end
         rbe_pkg::L_GRAV_MUL: begin
            mul_a    = {1'b0, cfg.gravity_accel};
            mul_b    = cfg.inv_mass;
            state_in = rbe_pkg::L_GRAV_ADD;
         end
         rbe_pkg::L_GRAV_ADD: begin
            // gravity acts on the vertical lane only
            if (grav_use) begin
               acc_in = rbe_pkg::sat32(acc_sum);
            end
            state_in = rbe_pkg::L_FRIC_MUL;
         end
         rbe_pkg::L_FRIC_MUL: begin
            mul_a    = vel_ff;
            mul_b    = cfg.friction_coeff;
            state_in = rbe_pkg::L_FRIC_SAT;
         end
         rbe_pkg::L_FRIC_SAT: begin
            opnd_in  = rbe_pkg::sat32(-sp);
            state_in = rbe_pkg::L_FMASS_MUL;
         end
         rbe_pkg::L_FMASS_MUL: begin
            mul_a    = opnd_ff;
            mul_b    = cfg.inv_mass;
            state_in = rbe_pkg::L_FMASS_ADD;
         end
         rbe_pkg::L_FMASS_ADD: begin
            acc_in   = rbe_pkg::sat32(acc_sum);
            state_in = rbe_pkg::L_VEL_MUL;
         end
         rbe_pkg::L_VEL_MUL: begin
            mul_a    = acc_ff;
            mul_b    = {16'd0, dt_ff};
            state_in = rbe_pkg::L_VEL_ADD;
         end
         rbe_pkg::L_VEL_ADD: begin
            vel_in   = settled;
            state_in = rbe_pkg::L_DISP_MUL;
         end
         rbe_pkg::L_DISP_MUL: begin
            mul_a    = vel_ff;
            mul_b    = {16'd0, dt_ff};
            state_in = rbe_pkg::L_DISP_SET;
         end
         rbe_pkg::L_DISP_SET: begin
            disp_in  = sp[31:0];
            acc_in   = '0;
            state_in = rbe_pkg::L_DONE;
         end
         rbe_pkg::L_DONE: begin
            if (ctl.ack) begin
               state_in = rbe_pkg::L_IDLE;
            end
         end
         default: state_in = rbe_pkg::L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbe_pkg::L_IDLE;
         vel_ff   <= '0;
         acc_ff   <= '0;
         disp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vel_ff   <= vel_in;
         acc_ff   <= acc_in;
         disp_ff  <= disp_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      dt_ff   <= dt_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
   end

   assign stat.done = (state_ff == rbe_pkg::L_DONE);
   assign vel       = vel_ff;
   assign disp      = disp_ff;

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == rbe_pkg::L_DISP_SET |=> acc_ff == '0)
      else $error("acceleration not cleared at end of tick");

   a_vel_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == rbe_pkg::L_VEL_ADD |=>
         (vel_ff <= $signed({1'b0, $past(limit)}) &&
          vel_ff >= -$signed({1'b0, $past(limit)})))
      else $error("velocity outside speed limit after tick");

   a_disp_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == rbe_pkg::L_IDLE && ctl.start && ctl.action != rbe_pkg::ACT_TICK
         |=> disp_ff == '0)
      else $error("displacement not zero for a non-tick word");

endmodule

// File: sv/rigid_body_euler_step.sv
// Top level of the two-axis rigid body integrator: channels, register port, lanes, merge.
// Two-axis semi-implicit Euler integrator in signed Q16.16. The x and y axes run in two
// identical lanes in lockstep, each with one 32x32 multiplier that is registered and
// reused for every product of an item; a merge register collects both lanes into one
// response word. One request word is worked at a time. A set-velocity or unused action goes
// straight to the done state; an apply-force steps through a multiply and an add; a time tick
// steps through friction, mass scaling, velocity and displacement products, each a multiply
// and a use of it, after a gravity multiply and add when gravity is enabled. In the done state
// the result moves into the response register once that register is free; the response is
// valid and the next request can be taken from the cycle after, even while the response still
// waits to be read. Configuration registers sit at byte addresses 0, 4, 8, 12 and 16; the user
// must write them only while the block is idle, and the block itself does not enforce this.
module rigid_body_euler_step (
   input  logic                       clock,
   input  logic                       reset,
   rbe_req_if.sink                    req,
   rbe_rsp_if.source                  rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rbe_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   rbe_pkg::cfg_type       cfg;
   rbe_pkg::lane_ctl_type  ctl;
   rbe_pkg::lane_stat_type x_stat;
   rbe_pkg::lane_stat_type y_stat;
   logic signed [31:0]     x_vel, y_vel, x_disp, y_disp;

   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] vx_ff, vy_ff, dx_ff, dy_ff;
   logic               accept;
   logic               load;

   rbe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign accept     = req.valid && req.ready;
   assign ctl.start  = accept;
   assign ctl.ack    = load;
   assign ctl.action = req.action;
   assign ctl.dt     = req.delta_time;

   rbe_lane u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .value    (req.value_x),
      .cfg      (cfg),
      .grav_use (1'b0),
      .limit    (cfg.speed_limit),
      .stat     (x_stat),
      .vel      (x_vel),
      .disp     (x_disp)
   );

   rbe_lane u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .value    (req.value_y),
      .cfg      (cfg),
      .grav_use (1'b1),
      .limit    (cfg.gravity_accel),
      .stat     (y_stat),
      .vel      (y_vel),
      .disp     (y_disp)
   );

   // merge both lanes once the response register is free
   assign load = busy_ff && x_stat.done && y_stat.done && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (load) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vx_ff <= x_vel;
         vy_ff <= y_vel;
         dx_ff <= x_disp;
         dy_ff <= y_disp;
      end
   end

   assign req.ready          = !busy_ff;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.velocity_x     = vx_ff;
   assign rsp.velocity_y     = vy_ff;
   assign rsp.displacement_x = dx_ff;
   assign rsp.displacement_y = dy_ff;

   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      x_stat.done == y_stat.done)
      else $error("axis lanes out of step");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted word not held busy");

   a_rsp_from_lanes: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff) && !busy_ff)
      else $error("response raised without a finished word");

endmodule

// File: bench/rigid_body_euler_step_test.sv
// Self-checking testbench of the rigid body integrator: stimulus, predictor and response checks.
`timescale 1ns / 1ps

module rigid_body_euler_step_test;

   localparam logic [1:0] ACT_UNUSED     = 2'd3;
   localparam logic [2:0] REG_SPARE_LO   = 3'd5;
   localparam logic [2:0] REG_SPARE_HI   = 3'd7;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned WORDS_PER_SET = 75;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
   } motion_word_type;

   // Tracks body state and register copies, predicts each response word in order
   class motion_scoreboard;
      logic [31:0]        inv_mass;
      logic [31:0]        friction;
      logic               grav_en;
      logic [30:0]        grav_acc;
      logic [30:0]        speed_limit;
      logic signed [31:0] vel_x, vel_y, acc_x, acc_y;
      motion_word_type    expected_motion[$];
      int unsigned        mismatches;
      int unsigned        checked;

      function new();
         inv_mass    = 32'd65536;
         friction    = 32'd0;
         grav_en     = 1'b0;
         grav_acc    = 31'd642252;
         speed_limit = 31'd655360;
         vel_x       = '0;
         vel_y       = '0;
         acc_x       = '0;
         acc_y       = '0;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            rbe_pkg::REG_INV_MASS:  inv_mass    = value;
            rbe_pkg::REG_FRICTION:  friction    = value;
            rbe_pkg::REG_GRAV_EN:   grav_en     = value[0];
            rbe_pkg::REG_GRAV_ACC:  grav_acc    = value[30:0];
            rbe_pkg::REG_SPEED_LIM: speed_limit = value[30:0];
            default: ;
         endcase
      endfunction

      // a * b / 2^16, truncated toward zero
      function longint scale(longint a, logic [31:0] b);
         logic [63:0] mag;
         logic [63:0] q;
         mag = (a < 0) ? 64'(-a) : 64'(a);
         q = (mag * {32'd0, b}) >> 16;
         return (a < 0) ? -longint'(q) : longint'(q);
      endfunction

      function logic signed [31:0] clip32(longint v);
         if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
         end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
         end
         return 32'(v);
      endfunction

      function logic signed [31:0] add_force(logic signed [31:0] acc, longint force_val);
         return clip32(longint'(acc) + scale(force_val, inv_mass));
      endfunction

      // clamp to +-limit, then drop anything within 1.0 of rest
      function logic signed [31:0] settle(longint v, longint limit);
         if (v > limit) begin
            v = limit;
         end
         if (v < -limit) begin
            v = -limit;
         end
         if (v >= -65536 && v <= 65536) begin
            v = 0;
         end
         return 32'(v);
      endfunction

      function void note_request(logic [1:0] action, logic signed [31:0] in_x,
                                 logic signed [31:0] in_y, logic [15:0] dt);
         motion_word_type w;
         longint          nx, ny;
         w.disp_x = '0;
         w.disp_y = '0;
         case (action)
            rbe_pkg::ACT_FORCE: begin
               acc_x = add_force(acc_x, longint'(in_x));
               acc_y = add_force(acc_y, longint'(in_y));
            end
            rbe_pkg::ACT_SETVEL: begin
               vel_x = in_x;
               vel_y = in_y;
            end
            rbe_pkg::ACT_TICK: begin
               if (grav_en) begin
                  acc_y = add_force(acc_y, longint'(grav_acc));
               end
               // friction uses the velocity from before the tick
               acc_x = add_force(acc_x, longint'(clip32(-scale(longint'(vel_x), friction))));
               acc_y = add_force(acc_y, longint'(clip32(-scale(longint'(vel_y), friction))));
               nx = longint'(vel_x) + scale(longint'(acc_x), {16'd0, dt});
               ny = longint'(vel_y) + scale(longint'(acc_y), {16'd0, dt});
               vel_x = settle(nx, longint'(speed_limit));
               vel_y = settle(ny, longint'(grav_acc));
               w.disp_x = 32'(scale(longint'(vel_x), {16'd0, dt}));
               w.disp_y = 32'(scale(longint'(vel_y), {16'd0, dt}));
               acc_x = '0;
               acc_y = '0;
            end
            default: ;
         endcase
         w.vel_x = vel_x;
         w.vel_y = vel_y;
         expected_motion.push_back(w);
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(motion_word_type got);
         motion_word_type want;
         if (expected_motion.size() == 0) begin
            $error("response word with nothing outstanding: vx %0d vy %0d dx %0d dy %0d",
                   got.vel_x, got.vel_y, got.disp_x, got.disp_y);
            mismatches++;
            return;
         end
         want = expected_motion.pop_front();
         checked++;
         compare_field("velocity_x", want.vel_x, got.vel_x);
         compare_field("velocity_y", want.vel_y, got.vel_y);
         compare_field("displacement_x", want.disp_x, got.disp_x);
         compare_field("displacement_y", want.disp_y, got.disp_y);
      endfunction

      function int unsigned pending();
         return expected_motion.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [rbe_pkg::CSR_AW-1:0] paddr;
   logic [31:0]                pwdata;
   logic [31:0]                prdata;
   logic                       pready;

   rbe_req_if req_ch();
   rbe_rsp_if rsp_ch();

   motion_scoreboard sb = new();
   bit          calm = 1'b0;
   int unsigned words_sent = 0;
   int unsigned ticks_sent = 0;
   int unsigned settings_used = 1;

   rigid_body_euler_step dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("** rigid_body_euler_step: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      motion_word_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_request(req_ch.action, req_ch.value_x, req_ch.value_y,
                            req_ch.delta_time);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.vel_x  = rsp_ch.velocity_x;
            got.vel_y  = rsp_ch.velocity_y;
            got.disp_x = rsp_ch.displacement_x;
            got.disp_y = rsp_ch.displacement_y;
            sb.check_response(got);
         end
      end
   end

   // Response side: random stall bursts, none once calm is set
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 7);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] rand_value();
      int s;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            s = int'($urandom_range(0, 33554432)) - 16777216;   // about +-256.0
            return 32'(s);
         end
         5: begin
            s = int'($urandom_range(0, 196608)) - 98304;        // within +-1.5
            return 32'(s);
         end
         6: begin
            case ($urandom_range(0, 5))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0001_0000;
               3:       return 32'hFFFF_0000;
               4:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] rand_dt();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 16'($urandom_range(256, 8192));
         6:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   // Entered and left just after a falling edge
   task automatic send_word(logic [1:0] action, logic [31:0] in_x, logic [31:0] in_y,
                            logic [15:0] dt);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= action;
      req_ch.value_x    <= in_x;
      req_ch.value_y    <= in_y;
      req_ch.delta_time <= dt;
      do @(posedge clock); while (!req_ch.ready);
      if (action != ACT_UNUSED) begin
         words_sent++;
      end
      if (action == rbe_pkg::ACT_TICK) begin
         ticks_sent++;
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic setup_random();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0:       v = 32'd0;
         1:       v = $urandom();
         2:       v = 32'hFFFF_FFFF;
         default: v = $urandom_range(4096, 262144);
      endcase
      write_csr(rbe_pkg::REG_INV_MASS, v);
      v = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 65536);
      write_csr(rbe_pkg::REG_FRICTION, v);
      write_csr(rbe_pkg::REG_GRAV_EN, {$urandom_range(0, 1) != 0 ? 31'($urandom()) : 31'd0,
                                       1'($urandom_range(0, 1))});
      case ($urandom_range(0, 5))
         0:       v = 32'd0;
         1:       v = $urandom();
         default: v = $urandom_range(65536, 1310720);
      endcase
      write_csr(rbe_pkg::REG_GRAV_ACC, {1'($urandom_range(0, 1)), v[30:0]});
      case ($urandom_range(0, 5))
         0:       v = 32'h7FFF_FFFF;
         1:       v = $urandom();
         default: v = $urandom_range(65536, 3276800);
      endcase
      write_csr(rbe_pkg::REG_SPEED_LIM, {1'($urandom_range(0, 1)), v[30:0]});
      settings_used++;
   endtask

   // Mostly force bursts, at times after a set-velocity, closed by a tick; some loose words of any action
   task automatic run_random(int unsigned count);
      int unsigned sent;
      int unsigned n;
      logic [1:0]  act;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 4) == 0) begin
               send_word(rbe_pkg::ACT_SETVEL, rand_value(), rand_value(), rand_dt());
               sent++;
            end
            n = $urandom_range(0, 3);
            repeat (n) begin
               send_word(rbe_pkg::ACT_FORCE, rand_value(), rand_value(), rand_dt());
               sent++;
            end
            send_word(rbe_pkg::ACT_TICK, rand_value(), rand_value(), rand_dt());
            sent++;
         end else begin
            act = 2'($urandom_range(0, 3));
            send_word(act, $urandom(), $urandom(), 16'($urandom()));
            if (act != ACT_UNUSED) begin
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_ch.valid      = 1'b0;
      req_ch.action     = rbe_pkg::ACT_FORCE;
      req_ch.value_x    = '0;
      req_ch.value_y    = '0;
      req_ch.delta_time = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: clamp, snap at exactly 1.0, raw velocity load, idle action
      send_word(rbe_pkg::ACT_TICK, 32'h0, 32'h0, 16'h0000);
      send_word(rbe_pkg::ACT_SETVEL, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
      send_word(ACT_UNUSED, 32'h1234_5678, 32'h8765_4321, 16'hFFFF);
      send_word(rbe_pkg::ACT_TICK, 32'h0, 32'h0, 16'hFFFF);
      send_word(rbe_pkg::ACT_SETVEL, 32'h0001_0000, 32'hFFFF_0000, 16'h0);
      send_word(rbe_pkg::ACT_TICK, 32'h0, 32'h0, 16'h0000);
      send_word(rbe_pkg::ACT_SETVEL, 32'h0001_0001, 32'hFFFE_FFFF, 16'h0);
      send_word(rbe_pkg::ACT_TICK, 32'h0, 32'h0, 16'h0000);
      // accumulator saturation both ways
      send_word(rbe_pkg::ACT_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
      send_word(rbe_pkg::ACT_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
      send_word(rbe_pkg::ACT_TICK, 32'h0, 32'h0, 16'hFFFF);
      send_word(rbe_pkg::ACT_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0);
      send_word(rbe_pkg::ACT_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0);
      send_word(rbe_pkg::ACT_TICK, 32'h0, 32'h0, 16'h0001);
      drain();

      // Every register at its top value, junk in the unused upper bits
      write_csr(rbe_pkg::REG_INV_MASS, 32'hFFFF_FFFF);
      write_csr(rbe_pkg::REG_FRICTION, 32'hFFFF_FFFF);
      write_csr(rbe_pkg::REG_GRAV_EN, 32'hFFFF_FFFF);
      write_csr(rbe_pkg::REG_GRAV_ACC, 32'hFFFF_FFFF);
      write_csr(rbe_pkg::REG_SPEED_LIM, 32'hFFFF_FFFF);
      settings_used++;
      // friction force saturates before the mass scaling
      send_word(rbe_pkg::ACT_SETVEL, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
      send_word(rbe_pkg::ACT_TICK, 32'h0, 32'h0, 16'hFFFF);
      send_word(rbe_pkg::ACT_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0);
      send_word(rbe_pkg::ACT_TICK, 32'h0, 32'h0, 16'h0001);
      run_random(WORDS_PER_SET / 2);
      drain();

      // Zero mass and limits, plus writes to unmapped slots that must not land
      write_csr(rbe_pkg::REG_INV_MASS, 32'h0);
      write_csr(rbe_pkg::REG_FRICTION, 32'h0);
      write_csr(rbe_pkg::REG_GRAV_EN, 32'h0);
      write_csr(rbe_pkg::REG_GRAV_ACC, 32'h0);
      write_csr(rbe_pkg::REG_SPEED_LIM, 32'h0);
      for (int unsigned i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
         write_csr(3'(i), $urandom());
      end
      settings_used++;
      send_word(rbe_pkg::ACT_SETVEL, 32'h0040_0000, 32'hFFC0_0000, 16'h0);
      send_word(rbe_pkg::ACT_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
      send_word(rbe_pkg::ACT_TICK, 32'h0, 32'h0, 16'hFFFF);
      run_random(WORDS_PER_SET / 2);
      drain();

      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         setup_random();
         if (p == RANDOM_PHASES - 1) begin
            calm = 1'b1;
         end
         run_random(WORDS_PER_SET);
         drain();
      end

      repeat (20) @(negedge clock);
      $display("Run covered %0d request words (%0d ticks) under %0d register settings;",
               words_sent, ticks_sent, settings_used);
      $display("%0d response words checked, %0d mismatches.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** rigid_body_euler_step: PASSED **");
      end else begin
         $display("** rigid_body_euler_step: FAILED **");
      end
      $finish;
   end

endmodule
